[design/bsdl_pkg.sv]
package bsdl_pkg;

   typedef enum logic [3:0] {
      OP_CLEAR      = 4'd0,
      OP_SORTED_INS = 4'd1,
      OP_DELETE_KEY = 4'd2,
      OP_INS_LAST   = 4'd3,
      OP_DEL_LAST   = 4'd4,
      OP_INS_FIRST  = 4'd5,
      OP_DEL_FIRST  = 4'd6,
      OP_INVERT     = 4'd7,
      OP_DUMP       = 4'd8
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef struct packed {
      logic [3:0]  operation;
      logic [31:0] key;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] key_out;
      logic [4:0]  entry_count;
      logic        last;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic latch_req;
      logic walk_start;
      logic walk_step;
      logic do_clear;
      logic do_invert;
      logic do_link;
      logic link_at_hit;
      logic link_front;
      logic do_unlink;
      logic unlink_hit;
      logic unlink_front;
   } bsdl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic full;
      logic empty;
      logic hit_ge;
      logic hit_eq;
      logic walk_end;
      logic walk_last;
   } bsdl_stat_type;

endpackage

[design/bsdl_if.sv]
interface bsdl_req_if;
   logic               valid;
   logic               ready;
   bsdl_pkg::req_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface bsdl_rsp_if;
   logic               valid;
   logic               ready;
   bsdl_pkg::rsp_type  payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[design/bounded_sorted_deque_list_top.sv]
// Bounded sorted deque list: a doubly linked list of signed keys in a node pool.
// req channel: one beat per command (operation, key); accepted on valid && ready.
// rsp channel: one beat per command, or one beat per held key for dump,
// with last set on the final beat of the command.
// Simple commands pass through S_EXEC and S_REPLY before their beat is loaded. Sorted
// insert and delete by key walk the list one node per cycle in S_WALK.
// Dump loads each key in S_DUMP and passes through S_DUMP_WAIT before the next key.
// Only one command is in flight; req_ready is high again after the last beat
// of a command has been loaded into the output register.
// Reset empties the list, frees every slot and clears the direction flag;
// key and link stores are not cleared.
// A stalled receiver holds the output register; the dump walk pauses until it drains.
module bounded_sorted_deque_list_top #(
   parameter int POOL_DEPTH = 16,
   parameter int KEY_BITS   = 32
) (
   input  logic       clock,
   input  logic       reset,
   bsdl_req_if.sink   req,
   bsdl_rsp_if.source rsp
);
   import bsdl_pkg::*;

   bsdl_cmd_type  cmd;
   bsdl_stat_type stat;
   logic [31:0]   cur_key;
   logic [4:0]    count;

   bsdl_ctrl u_ctrl (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready), .req_data(req.payload),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.payload),
      .cmd, .stat, .cur_key, .count
   );

   bsdl_datapath #(.POOL_DEPTH(POOL_DEPTH), .KEY_BITS(KEY_BITS)) u_dp (
      .clock, .reset, .req_data(req.payload), .cmd, .stat, .cur_key, .count
   );
endmodule

[design/bsdl_datapath.sv]
module bsdl_datapath #(
   parameter int POOL_DEPTH = 16,
   parameter int KEY_BITS   = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  bsdl_pkg::req_type       req_data,
   input  bsdl_pkg::bsdl_cmd_type  cmd,
   output bsdl_pkg::bsdl_stat_type stat,
   output logic [31:0]             cur_key,
   output logic [4:0]              count
);
   import bsdl_pkg::*;

   localparam int IW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
   localparam int CW = $clog2(POOL_DEPTH + 1);

   logic [KEY_BITS-1:0] keys_ff [POOL_DEPTH];
   logic [IW-1:0]       fwd_ff  [POOL_DEPTH];
   logic [IW-1:0]       bwd_ff  [POOL_DEPTH];
   logic [IW-1:0]       front_ff, back_ff, cur_ff;
   logic [CW-1:0]       held_ff, step_ff;
   logic [POOL_DEPTH-1:0] free_ff;
   logic                rev_ff;
   logic [KEY_BITS-1:0] key_ff;

   logic [IW-1:0] head, tail, nxt, prv, slot;
   logic signed [KEY_BITS-1:0] ck;
   logic [63:0] ext;

   assign head = rev_ff ? back_ff : front_ff;
   assign tail = rev_ff ? front_ff : back_ff;
   assign nxt  = rev_ff ? bwd_ff[cur_ff] : fwd_ff[cur_ff];
   assign prv  = rev_ff ? fwd_ff[cur_ff] : bwd_ff[cur_ff];
   assign ck   = keys_ff[cur_ff];

   always_comb begin
      slot = '0;
      for (int i = POOL_DEPTH - 1; i >= 0; i--) begin
         if (free_ff[i]) begin
            slot = IW'(i);
         end
      end
   end

   assign ext = 64'(ck);
   assign cur_key = ext[31:0];
   assign count = 5'(held_ff);
   assign stat.full = held_ff >= CW'(POOL_DEPTH);
   assign stat.empty = held_ff == '0;
   assign stat.hit_ge = ck >= $signed(key_ff);
   assign stat.hit_eq = ck == key_ff;
   assign stat.walk_end = step_ff == held_ff;
   assign stat.walk_last = (step_ff + CW'(1)) == held_ff;

   always_ff @(posedge clock) begin
      logic [IW-1:0] p, q, n;
      logic hp, hq;
      if (cmd.latch_req) begin
         key_ff <= KEY_BITS'({{32{req_data.key[31]}}, req_data.key});
      end
      if (cmd.walk_start) begin
         cur_ff <= head;
      end else if (cmd.walk_step) begin
         cur_ff <= nxt;
      end
      if (cmd.do_link) begin
         n = slot;
         keys_ff[n] <= key_ff;
         if (cmd.link_at_hit) begin
            hp = cur_ff != head; p = prv; hq = 1'b1; q = cur_ff;
         end else if (cmd.link_front) begin
            hp = 1'b0; p = '0; hq = held_ff != '0; q = head;
         end else begin
            hp = held_ff != '0; p = tail; hq = 1'b0; q = '0;
         end
         if (rev_ff) begin
            fwd_ff[n] <= hp ? p : n;
            bwd_ff[n] <= hq ? q : n;
            if (hp) bwd_ff[p] <= n;
            if (hq) fwd_ff[q] <= n;
         end else begin
            bwd_ff[n] <= hp ? p : n;
            fwd_ff[n] <= hq ? q : n;
            if (hp) fwd_ff[p] <= n;
            if (hq) bwd_ff[q] <= n;
         end
      end
      if (cmd.do_unlink) begin
         n = cmd.unlink_hit ? cur_ff : (cmd.unlink_front ? head : tail);
         hp = n != head;
         hq = n != tail;
         p = rev_ff ? fwd_ff[n] : bwd_ff[n];
         q = rev_ff ? bwd_ff[n] : fwd_ff[n];
         if (hp) begin
            if (rev_ff) bwd_ff[p] <= q; else fwd_ff[p] <= q;
         end
         if (hq) begin
            if (rev_ff) fwd_ff[q] <= p; else bwd_ff[q] <= p;
         end
      end
   end

   always_ff @(posedge clock) begin
      logic [IW-1:0] n, p, q;
      logic hp, hq;
      if (reset || cmd.do_clear) begin
         front_ff <= '0;
         back_ff  <= '0;
         held_ff  <= '0;
         free_ff  <= '1;
         rev_ff   <= 1'b0;
         step_ff  <= '0;
      end else begin
         if (cmd.walk_start) step_ff <= '0;
         else if (cmd.walk_step) step_ff <= step_ff + 1'b1;
         if (cmd.do_invert) rev_ff <= ~rev_ff;
         if (cmd.do_link) begin
            n = slot;
            free_ff[n] <= 1'b0;
            held_ff <= held_ff + 1'b1;
            if (cmd.link_at_hit) begin
               hp = cur_ff != head; hq = 1'b1;
            end else if (cmd.link_front) begin
               hp = 1'b0; hq = held_ff != '0;
            end else begin
               hp = held_ff != '0; hq = 1'b0;
            end
            if (!hp) begin
               if (rev_ff) back_ff <= n; else front_ff <= n;
            end
            if (!hq) begin
               if (rev_ff) front_ff <= n; else back_ff <= n;
            end
         end
         if (cmd.do_unlink) begin
            n = cmd.unlink_hit ? cur_ff : (cmd.unlink_front ? head : tail);
            hp = n != head;
            hq = n != tail;
            p = rev_ff ? fwd_ff[n] : bwd_ff[n];
            q = rev_ff ? bwd_ff[n] : fwd_ff[n];
            free_ff[n] <= 1'b1;
            held_ff <= held_ff - 1'b1;
            if (held_ff == CW'(1)) begin
               front_ff <= '0;
               back_ff  <= '0;
            end else begin
               if (!hp) begin
                  if (rev_ff) back_ff <= q; else front_ff <= q;
               end
               if (!hq) begin
                  if (rev_ff) front_ff <= p; else back_ff <= p;
               end
            end
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.do_link |=> held_ff == $past(held_ff) + 1'b1)
      else $error("link did not grow count");
   assert property (@(posedge clock) disable iff (reset)
      cmd.do_link |-> !stat.full)
      else $error("link into full pool");
   assert property (@(posedge clock) disable iff (reset)
      cmd.do_unlink |-> !stat.empty)
      else $error("unlink from empty list");
   assert property (@(posedge clock) disable iff (reset)
      $countones(~free_ff) == int'(held_ff))
      else $error("free mask disagrees with count");
endmodule

[design/bsdl_ctrl.sv]
module bsdl_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  bsdl_pkg::req_type       req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output bsdl_pkg::rsp_type       rsp_data,
   output bsdl_pkg::bsdl_cmd_type  cmd,
   input  bsdl_pkg::bsdl_stat_type stat,
   input  logic [31:0]             cur_key,
   input  logic [4:0]              count
);
   import bsdl_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_EXEC, S_WALK, S_REPLY, S_DUMP, S_DUMP_WAIT
   } state_type;

   state_type  state_ff;
   logic [3:0] op_ff;
   logic [1:0] status_ff;
   logic       valid_ff;
   rsp_type    out_ff;

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      cmd = '0;
      cmd.latch_req = req_valid && req_ready;
      case (state_ff)
         S_EXEC: begin
            case (op_ff)
               OP_CLEAR:    cmd.do_clear = 1'b1;
               OP_INS_LAST: cmd.do_link = !stat.full;
               OP_INS_FIRST: begin
                  cmd.do_link = !stat.full;
                  cmd.link_front = 1'b1;
               end
               OP_DEL_LAST: cmd.do_unlink = !stat.empty;
               OP_DEL_FIRST: begin
                  cmd.do_unlink = !stat.empty;
                  cmd.unlink_front = 1'b1;
               end
               OP_INVERT: cmd.do_invert = !stat.empty;
               OP_SORTED_INS, OP_DELETE_KEY, OP_DUMP: cmd.walk_start = 1'b1;
               default: ;
            endcase
         end
         S_WALK: begin
            if (stat.walk_end) begin
               cmd.do_link = op_ff == OP_SORTED_INS;
            end else if (op_ff == OP_SORTED_INS && stat.hit_ge) begin
               cmd.do_link = 1'b1;
               cmd.link_at_hit = 1'b1;
            end else if (op_ff == OP_DELETE_KEY && stat.hit_eq) begin
               cmd.do_unlink = 1'b1;
               cmd.unlink_hit = 1'b1;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         S_DUMP: cmd.walk_step = !valid_ff || rsp_ready;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         if (valid_ff && rsp_ready) valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  op_ff <= req_data.operation;
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               status_ff <= ST_OK;
               state_ff <= S_REPLY;
               case (op_ff)
                  OP_INS_LAST, OP_INS_FIRST: if (stat.full) status_ff <= ST_FULL;
                  OP_DEL_LAST, OP_DEL_FIRST, OP_INVERT:
                     if (stat.empty) status_ff <= ST_EMPTY;
                  OP_SORTED_INS: begin
                     if (stat.full) status_ff <= ST_FULL;
                     else state_ff <= S_WALK;
                  end
                  OP_DELETE_KEY: begin
                     if (stat.empty) status_ff <= ST_EMPTY;
                     else state_ff <= S_WALK;
                  end
                  OP_DUMP: begin
                     if (stat.empty) status_ff <= ST_EMPTY;
                     else state_ff <= S_DUMP;
                  end
                  default: ;
               endcase
            end
            S_WALK: begin
               if (stat.walk_end) begin
                  if (op_ff == OP_DELETE_KEY) status_ff <= ST_NOT_FOUND;
                  state_ff <= S_REPLY;
               end else if ((op_ff == OP_SORTED_INS && stat.hit_ge) ||
                            (op_ff == OP_DELETE_KEY && stat.hit_eq)) begin
                  state_ff <= S_REPLY;
               end
            end
            S_REPLY: begin
               if (!valid_ff || rsp_ready) begin
                  valid_ff <= 1'b1;
                  out_ff.status <= status_ff;
                  out_ff.key_out <= '0;
                  out_ff.entry_count <= count;
                  out_ff.last <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            S_DUMP: begin
               if (!valid_ff || rsp_ready) begin
                  valid_ff <= 1'b1;
                  out_ff.status <= ST_OK;
                  out_ff.key_out <= cur_key;
                  out_ff.entry_count <= count;
                  out_ff.last <= stat.walk_last;
                  state_ff <= S_DUMP_WAIT;
               end
            end
            S_DUMP_WAIT: begin
               state_ff <= out_ff.last ? S_IDLE : S_DUMP;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("beat dropped while stalled");
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second request taken while busy");
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.do_link, cmd.do_unlink, cmd.do_clear, cmd.do_invert}))
      else $error("conflicting datapath commands");
endmodule

[dv/tb.sv]
module tb;
   import bsdl_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int POOL       = 16;
   localparam int WDOG_LIMIT = 3000;
   localparam int HOLD_LEN   = 300;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bsdl_req_if req ();
   bsdl_rsp_if rsp ();

   bounded_sorted_deque_list_top u_top (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   logic signed [31:0] held_keys[$];
   rsp_type            pending_rsp[$];
   int                 err_count = 0;
   int                 quiet_cycles = 0;
   bit                 idle_on = 1'b1;
   bit                 hold_go = 1'b0;
   bit                 rsp_hold = 1'b0;

   task automatic report(input string msg);
      $display("mismatch: %s", msg);
      err_count++;
   endtask

   function automatic void push_rsp(input status_type st, input logic [31:0] k, input bit lst);
      rsp_type r;
      r.status      = st;
      r.key_out     = k;
      r.entry_count = 5'(held_keys.size());
      r.last        = lst;
      pending_rsp.push_back(r);
   endfunction

   // list kept in current logical order; invert just reverses it
   function automatic void predict_list(input req_type r);
      logic signed [31:0] k;
      int                 pos;
      status_type         st;
      k   = r.key;
      st  = ST_OK;
      pos = -1;
      case (r.operation)
         OP_CLEAR: held_keys.delete();
         OP_SORTED_INS, OP_INS_LAST, OP_INS_FIRST: begin
            if (held_keys.size() >= POOL) begin
               st = ST_FULL;
            end else if (r.operation == OP_INS_LAST) begin
               held_keys.push_back(k);
            end else if (r.operation == OP_INS_FIRST) begin
               held_keys.push_front(k);
            end else begin
               foreach (held_keys[i]) begin
                  if (pos < 0 && held_keys[i] >= k) pos = i;
               end
               if (pos < 0) held_keys.push_back(k);
               else held_keys.insert(pos, k);
            end
         end
         OP_DELETE_KEY: begin
            if (held_keys.size() == 0) begin
               st = ST_EMPTY;
            end else begin
               foreach (held_keys[i]) begin
                  if (pos < 0 && held_keys[i] == k) pos = i;
               end
               if (pos < 0) st = ST_NOT_FOUND;
               else held_keys.delete(pos);
            end
         end
         OP_DEL_LAST, OP_DEL_FIRST, OP_INVERT: begin
            if (held_keys.size() == 0) st = ST_EMPTY;
            else if (r.operation == OP_DEL_LAST) void'(held_keys.pop_back());
            else if (r.operation == OP_DEL_FIRST) void'(held_keys.pop_front());
            else held_keys.reverse();
         end
         OP_DUMP: begin
            if (held_keys.size() == 0) begin
               st = ST_EMPTY;
            end else begin
               foreach (held_keys[i]) push_rsp(ST_OK, held_keys[i], i == held_keys.size() - 1);
               return;
            end
         end
         default: ;
      endcase
      push_rsp(st, 32'd0, 1'b1);
   endfunction

   // check results, then predict from accepted commands
   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset) begin
         if (rsp.valid && rsp.ready) begin
            got = rsp.payload;
            if (pending_rsp.size() == 0) begin
               report($sformatf("unexpected beat %p", got));
            end else begin
               want = pending_rsp.pop_front();
               if (got.status !== want.status)
                  report($sformatf("status %0d want %0d", got.status, want.status));
               if (got.key_out !== want.key_out)
                  report($sformatf("key_out %h want %h", got.key_out, want.key_out));
               if (got.entry_count !== want.entry_count)
                  report($sformatf("entry_count %0d want %0d", got.entry_count,
                                   want.entry_count));
               if (got.last !== want.last)
                  report($sformatf("last %0b want %0b", got.last, want.last));
            end
         end
         if (req.valid && req.ready) predict_list(req.payload);
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      forever begin
         wait (hold_go);
         rsp_hold = 1'b1;
         repeat (HOLD_LEN) @(negedge clock);
         rsp_hold = 1'b0;
         hold_go  = 1'b0;
      end
   end

   initial rsp.ready = 1'b0;
   always @(negedge clock) begin
      rsp.ready <= !rsp_hold && !(idle_on && $urandom_range(99) < 21);
   end

   task automatic send_cmd(input logic [3:0] op, input logic [31:0] k);
      req_type r;
      r.operation = op;
      r.key       = k;
      @(negedge clock);
      if (idle_on && $urandom_range(99) < 21) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(negedge clock);
      end
      req.valid   <= 1'b1;
      req.payload <= r;
      do @(posedge clock); while (!req.ready);
   endtask

   task automatic drain();
      @(negedge clock);
      req.valid <= 1'b0;
      wait (pending_rsp.size() == 0);
   endtask

   function automatic logic [31:0] pick_key();
      int sel;
      sel = $urandom_range(99);
      if (sel < 45) return 32'($signed($urandom_range(16)) - 8);
      if (sel < 60) begin
         case ($urandom_range(3))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            default: return 32'h0;
         endcase
      end
      return $urandom;
   endfunction

   task automatic test_empty_and_extremes();
      send_cmd(OP_CLEAR, 32'h0);
      send_cmd(OP_DUMP, 32'h0);
      send_cmd(OP_DEL_FIRST, 32'h0);
      send_cmd(OP_DEL_LAST, 32'h0);
      send_cmd(OP_DELETE_KEY, 32'h5);
      send_cmd(OP_INVERT, 32'h0);
      send_cmd(OP_INS_FIRST, 32'h8000_0000);
      send_cmd(OP_INS_LAST, 32'h7fff_ffff);
      send_cmd(OP_SORTED_INS, 32'hffff_ffff);
      send_cmd(OP_SORTED_INS, 32'h5);
      send_cmd(OP_SORTED_INS, 32'h5);
      send_cmd(OP_DELETE_KEY, 32'h3);
      send_cmd(OP_DELETE_KEY, 32'h5);
      send_cmd(OP_DUMP, 32'h0);
      send_cmd(OP_INVERT, 32'h0);
      send_cmd(OP_SORTED_INS, 32'h0);
      send_cmd(OP_DUMP, 32'h0);
      send_cmd(OP_INS_FIRST, 32'h1);
      send_cmd(OP_DEL_LAST, 32'h0);
      send_cmd(OP_DEL_FIRST, 32'h0);
      send_cmd(4'hf, 32'hffff_ffff);
      send_cmd(4'h9, 32'h0);
      send_cmd(OP_DUMP, 32'h0);
      send_cmd(OP_CLEAR, 32'h0);
      send_cmd(OP_DUMP, 32'h0);
   endtask

   task automatic test_full_pool();
      for (int i = 0; i < POOL; i++) send_cmd(OP_SORTED_INS, $urandom);
      send_cmd(OP_SORTED_INS, 32'h0);
      send_cmd(OP_INS_LAST, 32'h0);
      send_cmd(OP_INS_FIRST, 32'h0);
      send_cmd(OP_DUMP, 32'h0);
      send_cmd(OP_INVERT, 32'h0);
      send_cmd(OP_DUMP, 32'h0);
   endtask

   task automatic test_backpressure();
      hold_go = 1'b1;
      for (int i = 0; i < 6; i++) send_cmd(OP_SORTED_INS, pick_key());
      send_cmd(OP_DUMP, 32'h0);
      drain();
      wait (!hold_go);
   endtask

   task automatic test_random();
      int          sel;
      logic [31:0] k;
      for (int n = 0; n < 75; n++) begin
         idle_on = !(n >= 20 && n < 45);
         sel = $urandom_range(99);
         k   = pick_key();
         if (sel < 30) send_cmd(OP_SORTED_INS, k);
         else if (sel < 40) send_cmd(OP_INS_LAST, k);
         else if (sel < 48) send_cmd(OP_INS_FIRST, k);
         else if (sel < 62) begin
            if (held_keys.size() > 0 && $urandom_range(9) < 7)
               k = held_keys[$urandom_range(held_keys.size() - 1)];
            send_cmd(OP_DELETE_KEY, k);
         end
         else if (sel < 70) send_cmd(OP_DEL_LAST, k);
         else if (sel < 78) send_cmd(OP_DEL_FIRST, k);
         else if (sel < 83) send_cmd(OP_INVERT, k);
         else if (sel < 91) send_cmd(OP_DUMP, k);
         else if (sel < 94) send_cmd(OP_CLEAR, k);
         else send_cmd(4'($urandom_range(15, 9)), k);
      end
      idle_on = 1'b1;
   endtask

   initial begin
      req.valid   = 1'b0;
      req.payload = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_empty_and_extremes();
      test_full_pool();
      drain();
      test_backpressure();
      send_cmd(OP_CLEAR, 32'h0);
      test_random();
      send_cmd(OP_DUMP, 32'h0);
      drain();
      repeat (40) @(posedge clock);
      if (err_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule

[sim.f]
design/bsdl_pkg.sv
design/bsdl_if.sv
design/bsdl_datapath.sv
design/bsdl_ctrl.sv
design/bounded_sorted_deque_list_top.sv
dv/tb.sv
